### sv/wfd_pkg.sv
// Package: types, codes and float conversion for the word frame deframer.
package wfd_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value_bits;
        logic [7:0]  word_index;
    } t_out_item;

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_PAYLOAD  = 3'd1,
        PH_TAIL     = 3'd2,
        PH_COMPLETE = 3'd3,
        PH_DISCARD  = 3'd4
    } t_phase;

    localparam logic [1:0] KIND_VALUE = 2'd0;
    localparam logic [1:0] KIND_GOOD  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [7:0] SYNC_A = 8'h8A;
    localparam logic [7:0] SYNC_B = 8'h5A;
    localparam logic [7:0] PAD    = 8'h00;

    // int32 to float32, round to nearest even
    function automatic logic [31:0] int_to_float(input logic [31:0] w);
        logic        s;
        logic [31:0] m;
        logic [31:0] n;
        logic [4:0]  lz;
        logic [4:0]  msb;
        logic [23:0] mant;
        logic        g;
        logic        st;
        logic [24:0] rm;
        logic [7:0]  e;
        s  = w[31];
        m  = s ? (~w + 32'd1) : w;
        lz = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (m[i]) lz = 5'(i);
        end
        msb = lz;
        n   = m << (5'd31 - msb);
        mant = n[31:8];
        g    = n[7];
        st   = |n[6:0];
        rm   = {1'b0, mant} + 25'((g && (st || mant[0])) ? 1 : 0);
        e    = 8'd127 + {3'd0, msb};
        if (m == 32'd0) begin
            int_to_float = 32'd0;
        end else if (rm[24]) begin
            int_to_float = {s, e + 8'd1, 23'd0};
        end else begin
            int_to_float = {s, e, rm[22:0]};
        end
    endfunction

endpackage

### sv/wfd_parse.sv
// Frame parser: phase tracking and word assembly for one byte per cycle while i_en is high.
module wfd_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  wfd_pkg::t_in_item i_item,
    output logic              o_have,
    output logic [1:0]        o_kind,
    output logic [31:0]       o_word,
    output logic [7:0]        o_index
);
    import wfd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_pos, n_pos;
    logic [7:0]  r_exp, n_exp;
    logic [7:0]  r_rcv, n_rcv;
    logic [23:0] r_asm, n_asm;
    logic [7:0]  hp, tp;
    logic        val;
    logic [7:0]  b;

    assign b = i_item.data_byte;

    always_comb begin
        case (r_pos)
            2'd0:    begin hp = SYNC_A; tp = SYNC_B; end
            2'd3:    begin hp = SYNC_B; tp = SYNC_A; end
            default: begin hp = PAD;    tp = PAD;    end
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_exp   = r_exp;
        n_rcv   = r_rcv;
        n_asm   = r_asm;
        val     = 1'b0;
        o_word  = {r_asm, b};
        o_index = r_rcv;
        case (r_phase)
            PH_HEADER: begin
                if (r_pos == 2'd2) begin
                    n_exp = b;
                    n_pos = 2'd3;
                end else if (b != hp) begin
                    n_phase = PH_DISCARD;
                end else if (r_pos == 2'd3) begin
                    n_pos   = 2'd0;
                    n_rcv   = 8'd0;
                    n_phase = (r_exp == 8'd0) ? PH_TAIL : PH_PAYLOAD;
                end else begin
                    n_pos = r_pos + 2'd1;
                end
            end
            PH_PAYLOAD: begin
                if (r_pos == 2'd3) begin
                    val   = 1'b1;
                    n_rcv = r_rcv + 8'd1;
                    n_asm = 24'd0;
                    n_pos = 2'd0;
                    if (n_rcv == r_exp) n_phase = PH_TAIL;
                end else begin
                    n_asm = {r_asm[15:0], b};
                    n_pos = r_pos + 2'd1;
                end
            end
            PH_TAIL: begin
                if (b != tp) begin
                    n_phase = PH_DISCARD;
                end else if (r_pos == 2'd3) begin
                    n_pos   = 2'd0;
                    n_phase = PH_COMPLETE;
                end else begin
                    n_pos = r_pos + 2'd1;
                end
            end
            default: n_phase = PH_DISCARD;
        endcase
        o_have = val || i_item.buffer_end;
        o_kind = !i_item.buffer_end ? KIND_VALUE :
                 (n_phase == PH_COMPLETE) ? KIND_GOOD : KIND_ERROR;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_item.buffer_end)) begin
            r_phase <= PH_HEADER;
            r_pos   <= 2'd0;
            r_exp   <= 8'd0;
            r_rcv   <= 8'd0;
            r_asm   <= 24'd0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_exp   <= n_exp;
            r_rcv   <= n_rcv;
            r_asm   <= n_asm;
        end
    end
endmodule

### sv/word_frame_deframer.sv
// Top level: input register, frame parser, float conversion and output register.
//  channel | signals                  | payload
//  in      | i_in_valid / o_in_ready  | t_in_item  {data_byte, buffer_end}
//  out     | o_out_valid / i_out_ready| t_out_item {kind, value_bits, word_index}
// One byte per cycle while the output is not stalled; a result passes the input and output registers.
// Input register feeds the parser; the output register holds a result under stall.
// Reset clears phase, counters and both valid bits.
// Backpressure stalls the parser and output register together; no transfer is lost.
module word_frame_deframer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  wfd_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output wfd_pkg::t_out_item  o_out_data
);
    import wfd_pkg::*;

    logic       r_iv;
    t_in_item   r_in;
    logic       r_ov;
    t_out_item  r_out;
    logic       adv;
    logic       have;
    logic [1:0] kind;
    logic [31:0] word;
    logic [7:0] idx;

    assign adv        = !r_ov || i_out_ready;
    assign o_in_ready = adv || !r_iv;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    wfd_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_iv && adv),
        .i_item  (r_in),
        .o_have  (have),
        .o_kind  (kind),
        .o_word  (word),
        .o_index (idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (o_in_ready) r_iv <= i_in_valid;
            if (adv)        r_ov <= r_iv && have;
        end
        if (o_in_ready && i_in_valid) r_in <= i_in_data;
        if (adv && r_iv && have) begin
            r_out.kind       <= kind;
            r_out.value_bits <= (kind == KIND_VALUE) ? int_to_float(word) : 32'd0;
            r_out.word_index <= (kind == KIND_VALUE) ? idx : 8'd0;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !i_out_ready |=> r_ov && $stable(r_out)) else $error("out held");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_out.kind == KIND_VALUE || r_out.kind == KIND_GOOD ||
                  r_out.kind == KIND_ERROR)) else $error("bad kind");
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_out.kind != KIND_VALUE |-> r_out.value_bits == 32'd0)
        else $error("status value");
endmodule

### bench/tb_top.sv
// Testbench for word_frame_deframer: frame stimulus, float predictor and result checks.
`timescale 1ns / 100ps

class frame_scoreboard;
    wfd_pkg::t_out_item pending_results[$];
    logic [2:0]  ph;
    logic [1:0]  pos;
    logic [7:0]  n_expected;
    logic [7:0]  n_received;
    logic [23:0] partial_word;
    int          errors;
    int          n_values;
    int          n_good;
    int          n_bad;

    function void clear_frame();
        ph = wfd_pkg::PH_HEADER;
        pos = 2'd0;
        n_expected = 8'd0;
        n_received = 8'd0;
        partial_word = 24'd0;
    endfunction

    // int32 to float32, round to nearest even, via the exact double value
    function logic [31:0] word_as_float(logic [31:0] w);
        logic [63:0] d;
        logic [23:0] m;
        logic [7:0]  e;
        if (w == 32'd0) return 32'd0;
        d = $realtobits(real'($signed(w)));
        m = {1'b0, d[51:29]} + 24'(d[28] && (d[29] || (|d[27:0])));
        e = 8'(d[62:52] - 11'd896);
        if (m[23]) e = e + 8'd1;
        return {d[63], e, m[22:0]};
    endfunction

    function void note_input(wfd_pkg::t_in_item it);
        wfd_pkg::t_out_item r;
        logic [31:0] w;
        logic have_value;
        logic [7:0] hp;
        logic [7:0] tp;
        have_value = 1'b0;
        r = '0;
        case (pos)
            2'd0: begin hp = wfd_pkg::SYNC_A; tp = wfd_pkg::SYNC_B; end
            2'd1: begin hp = wfd_pkg::PAD;    tp = wfd_pkg::PAD;    end
            2'd2: begin hp = wfd_pkg::PAD;    tp = wfd_pkg::PAD;    end
            default: begin hp = wfd_pkg::SYNC_B; tp = wfd_pkg::SYNC_A; end
        endcase
        case (ph)
            wfd_pkg::PH_HEADER: begin
                if (pos == 2'd2) n_expected = it.data_byte;
                if (pos != 2'd2 && it.data_byte != hp) begin
                    ph = wfd_pkg::PH_DISCARD;
                end else if (pos == 2'd3) begin
                    pos = 2'd0;
                    n_received = 8'd0;
                    ph = (n_expected == 0) ? wfd_pkg::PH_TAIL
                                           : wfd_pkg::PH_PAYLOAD;
                end else begin
                    pos = pos + 2'd1;
                end
            end
            wfd_pkg::PH_PAYLOAD: begin
                if (pos == 2'd3) begin
                    w = {partial_word, it.data_byte};
                    have_value = 1'b1;
                    r.kind = wfd_pkg::KIND_VALUE;
                    r.value_bits = word_as_float(w);
                    r.word_index = n_received;
                    n_received = n_received + 8'd1;
                    partial_word = 24'd0;
                    pos = 2'd0;
                    if (n_received == n_expected) ph = wfd_pkg::PH_TAIL;
                end else begin
                    partial_word = {partial_word[15:0], it.data_byte};
                    pos = pos + 2'd1;
                end
            end
            wfd_pkg::PH_TAIL: begin
                if (it.data_byte != tp) begin
                    ph = wfd_pkg::PH_DISCARD;
                end else if (pos == 2'd3) begin
                    pos = 2'd0;
                    ph = wfd_pkg::PH_COMPLETE;
                end else begin
                    pos = pos + 2'd1;
                end
            end
            default: ph = wfd_pkg::PH_DISCARD;
        endcase
        if (it.buffer_end) begin
            r = '0;
            r.kind = (ph == wfd_pkg::PH_COMPLETE) ? wfd_pkg::KIND_GOOD
                                                  : wfd_pkg::KIND_ERROR;
            if (ph == wfd_pkg::PH_COMPLETE) n_good++; else n_bad++;
            clear_frame();
            pending_results.push_back(r);
        end else if (have_value) begin
            n_values++;
            pending_results.push_back(r);
        end
    endfunction

    function void check_result(wfd_pkg::t_out_item got);
        wfd_pkg::t_out_item exp_r;
        if (pending_results.size() == 0) begin
            $error("unexpected result kind=%0d value=%h", got.kind, got.value_bits);
            errors++;
            return;
        end
        exp_r = pending_results.pop_front();
        if (got.kind !== exp_r.kind) begin
            $error("kind: expected %0d actual %0d", exp_r.kind, got.kind);
            errors++;
        end
        if (got.value_bits !== exp_r.value_bits) begin
            $error("value_bits: expected %h actual %h", exp_r.value_bits, got.value_bits);
            errors++;
        end
        if (got.word_index !== exp_r.word_index) begin
            $error("word_index: expected %0d actual %0d", exp_r.word_index, got.word_index);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import wfd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    frame_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_off;
    int  cycles;
    int  bytes_sent;

    word_frame_deframer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        sb = new();
        sb.clear_frame();
        cycles = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: random stalls plus a long hold-off when requested
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_byte(logic [7:0] b, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{data_byte: b, buffer_end: last};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input('{data_byte: b, buffer_end: last});
        bytes_sent++;
    endtask

    // well-formed frame; corrupt selects a fault: 0 none, 1 header, 2 tail,
    // 3 early end, 4 extra bytes
    task automatic send_frame(int n, int corrupt);
        logic [7:0] fr[$];
        logic [31:0] w;
        int cut;
        fr = '{SYNC_A, PAD, 8'(n), SYNC_B};
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(3))
                0: w = $urandom();
                1: w = 32'($signed($urandom_range(2000)) - 1000);
                2: w = {{8{1'($urandom_range(1))}}, 24'($urandom())};
                default: w = 32'h1 << $urandom_range(31) | $urandom_range(255);
            endcase
            fr.push_back(w[31:24]); fr.push_back(w[23:16]);
            fr.push_back(w[15:8]);  fr.push_back(w[7:0]);
        end
        fr.push_back(SYNC_B); fr.push_back(PAD); fr.push_back(PAD); fr.push_back(SYNC_A);
        case (corrupt)
            1: begin
                cut = $urandom_range(3);
                if (cut == 2) cut = 3;
                fr[cut] ^= 8'($urandom_range(1, 255));
            end
            2: begin
                cut = fr.size() - 1 - $urandom_range(3);
                fr[cut] ^= 8'($urandom_range(1, 255));
            end
            3: fr = fr[0:$urandom_range(fr.size() - 2)];
            4: repeat ($urandom_range(1, 3)) fr.push_back(8'($urandom()));
            default: ;
        endcase
        for (int k = 0; k < fr.size(); k++) send_byte(fr[k], k == fr.size() - 1);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        bytes_sent = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, empty frame, each fault kind, lone bytes
        send_frame(0, 0);
        send_frame(1, 0);
        begin
            logic [7:0] fx[$];
            fx = '{SYNC_A, PAD, 8'd4, SYNC_B,
                   8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h00,
                   8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                   SYNC_B, PAD, PAD, SYNC_A};
            foreach (fx[k]) send_byte(fx[k], k == fx.size() - 1);
        end
        send_frame(2, 1);
        send_frame(2, 2);
        send_frame(3, 3);
        send_frame(0, 4);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        drain();

        for (int phase_i = 0; phase_i < 4; phase_i++) begin
            send_idle_pct  = (phase_i == 1 || phase_i == 3) ? ((phase_i == 3) ? 27 : 45) : 0;
            recv_stall_pct = (phase_i == 2 || phase_i == 3) ? ((phase_i == 3) ? 27 : 45) : 0;
            if (phase_i == 2) hold_off = 300;
            for (int f = 0; f < 14; f++) begin
                int sel;
                sel = $urandom_range(9);
                if (sel == 9) begin
                    repeat ($urandom_range(1, 6))
                        send_byte(8'($urandom()), $urandom_range(3) == 0);
                    send_byte(8'($urandom()), 1'b1);
                end else begin
                    send_frame((f == 13 && phase_i == 0) ? 255 :
                               $urandom_range(0, 6), (sel < 6) ? 0 : sel - 5);
                end
            end
            drain();
        end

        $display("Run covered %0d bytes: %0d payload values, %0d good and %0d bad frames.",
                 bytes_sent, sb.n_values, sb.n_good, sb.n_bad);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
